>>> design/bles_pkg.sv
// shared constants, codes, reply texts and helpers for the reply line sequencer
package bles_pkg;

    // line store geometry
    localparam int LINE_DEPTH = 128;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);

    // characters walked at a line end (longest text is "Connection End")
    localparam int SCAN_LEN = 14;
    localparam int IDX_W    = $clog2(SCAN_LEN);

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_OVERRUN = 2'd1,
        OP_INIT    = 2'd2,
        OP_RSVD    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REP_NONE   = 2'd0,
        REP_CMD    = 2'd1,
        REP_AOK    = 2'd2,
        REP_REBOOT = 2'd3
    } t_reply;

    // command numbers
    localparam logic [3:0] CMD_NONE = 4'd0;
    localparam logic [3:0] CMD_R1   = 4'd1;
    localparam logic [3:0] CMD_SF   = 4'd2;
    localparam logic [3:0] CMD_SN   = 4'd3;
    localparam logic [3:0] CMD_SDR  = 4'd4;
    localparam logic [3:0] CMD_SS   = 4'd5;
    localparam logic [3:0] CMD_SR   = 4'd6;
    localparam logic [3:0] CMD_CUWC = 4'd7;
    localparam logic [3:0] CMD_CURV = 4'd8;

    // event codes
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_SET_TIME  = 3'd1;
    localparam logic [2:0] EV_LOCATING  = 3'd2;
    localparam logic [2:0] EV_ALERT_SMS = 3'd3;
    localparam logic [2:0] EV_CONNECTED = 3'd4;

    // link states
    localparam logic [3:0] LS_ERROR      = 4'd0;
    localparam logic [3:0] LS_START      = 4'd1;
    localparam logic [3:0] LS_INIT       = 4'd8;
    localparam logic [3:0] LS_CONNECTING = 4'd9;
    localparam logic [3:0] LS_CONNECTED  = 4'd10;

    localparam logic [7:0] CHAR_NL = 8'h0A;

    // line lengths that carry a time report, a locate and a notify
    localparam logic [ADDR_W-1:0] LEN_TIME   = ADDR_W'(24);
    localparam logic [ADDR_W-1:0] LEN_LOCATE = ADDR_W'(8);
    localparam logic [ADDR_W-1:0] LEN_NOTIFY = ADDR_W'(18);

    // positions of the time digits
    localparam logic [IDX_W-1:0] POS_HR_HI = IDX_W'(10);
    localparam logic [IDX_W-1:0] POS_HR_LO = IDX_W'(11);
    localparam logic [IDX_W-1:0] POS_MN_HI = IDX_W'(12);
    localparam logic [IDX_W-1:0] POS_MN_LO = IDX_W'(13);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SCAN_LEN - 1);

    // reply texts
    localparam int NPAT       = 8;
    localparam int PAT_R      = 0;
    localparam int PAT_NOTIFY = 1;
    localparam int PAT_ERR    = 2;
    localparam int PAT_CMD    = 3;
    localparam int PAT_AOK    = 4;
    localparam int PAT_REBOOT = 5;
    localparam int PAT_CONEND = 6;
    localparam int PAT_CONN   = 7;

    localparam logic [IDX_W-1:0] PAT_LEN [NPAT] = '{
        IDX_W'(2), IDX_W'(7), IDX_W'(3), IDX_W'(3),
        IDX_W'(3), IDX_W'(6), IDX_W'(14), IDX_W'(9)
    };

    localparam logic [7:0] PAT_TXT [NPAT][SCAN_LEN] = '{
        '{"R", ",", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0,
          8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
        '{"N", "o", "t", "i", "f", "y", ",",
          8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
        '{"E", "R", "R", 8'h0, 8'h0, 8'h0, 8'h0,
          8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
        '{"C", "M", "D", 8'h0, 8'h0, 8'h0, 8'h0,
          8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
        '{"A", "O", "K", 8'h0, 8'h0, 8'h0, 8'h0,
          8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
        '{"R", "e", "b", "o", "o", "t", 8'h0,
          8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
        '{"C", "o", "n", "n", "e", "c", "t",
          "i", "o", "n", " ", "E", "n", "d"},
        '{"C", "o", "n", "n", "e", "c", "t",
          "e", "d", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0}
    };

    // ascii hex digit to value, modulo 256
    function automatic logic [7:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c > 8'h39) begin
            v = c - 8'h37;
        end else begin
            v = c - 8'h30;
        end
        return v;
    endfunction

endpackage

>>> design/ble_module_reply_line_sequencer.sv
// top level: collects reply lines and runs the setup and classify sequencer
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------
//  input    | i_in_valid / o_in_ready    | i_op, i_rx_byte
//  output   | o_out_valid / i_out_ready  | o_command_id, o_event_code, o_hour_value,
//           |                            | o_minute_value, o_link_state_out
//
// a byte, overrun or initialize item gives its result in the cycle after accept
// a newline walks the first 14 stored characters through the single read port of
// the line store and one character compare stage, then passes S_DRAIN and S_DECIDE
// o_in_ready is high only when idle and the output register is empty
// i_rst_n is synchronous; the line store contents are not cleared
module ble_module_reply_line_sequencer
    import bles_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_op,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_command_id,
    output logic [2:0] o_event_code,
    output logic [7:0] o_hour_value,
    output logic [7:0] o_minute_value,
    output logic [3:0] o_link_state_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } t_state;

    t_state            r_state;
    logic [ADDR_W-1:0] r_len;
    logic [3:0]        r_link;
    t_reply            r_exp;
    logic              r_out_valid;
    logic [3:0]        r_cmd;
    logic [2:0]        r_ev;
    logic [7:0]        r_hr;
    logic [7:0]        r_mn;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic              r_cmp_on;
    logic [NPAT-1:0]   r_flag;
    logic [3:0]        r_hr_hi;
    logic [7:0]        r_hr_lo;
    logic [3:0]        r_mn_hi;
    logic [7:0]        r_mn_lo;

    logic              in_acc;
    logic              wr_en;
    logic [7:0]        rd_data;
    logic [7:0]        dig;
    logic [NPAT-1:0]   n_flag;
    logic [NPAT-1:0]   match;
    logic              reply_ok;
    logic [3:0]        n_link;
    t_reply            n_exp;
    logic [3:0]        n_cmd;
    logic [2:0]        n_ev;
    logic [7:0]        n_hr;
    logic [7:0]        n_mn;

    assign o_in_ready = (r_state == S_IDLE) && !r_out_valid;
    assign in_acc     = i_in_valid && o_in_ready;
    assign wr_en      = in_acc && (t_op'(i_op) == OP_BYTE) && (i_rx_byte != CHAR_NL);

    bles_line_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_len),
        .i_wr_data (i_rx_byte),
        .i_rd_addr (ADDR_W'(r_idx)),
        .o_rd_data (rd_data)
    );

    // character compare stage: one stored character against every reply text
    always_comb begin
        n_flag = r_flag;
        for (int p = 0; p < NPAT; p++) begin
            if ((r_cmp_idx < PAT_LEN[p]) && (rd_data != PAT_TXT[p][r_cmp_idx])) begin
                n_flag[p] = 1'b0;
            end
        end
    end

    assign dig = hex_val(rd_data);

    // a text matches only if the line is longer than it
    always_comb begin
        for (int p = 0; p < NPAT; p++) begin
            match[p] = r_flag[p] && (r_len > ADDR_W'(PAT_LEN[p]));
        end
    end

    always_comb begin
        case (r_exp)
            REP_CMD:    reply_ok = match[PAT_CMD];
            REP_AOK:    reply_ok = match[PAT_AOK];
            REP_REBOOT: reply_ok = match[PAT_REBOOT];
            default:    reply_ok = 1'b1;
        endcase
    end

    // line end decision
    always_comb begin
        n_link = r_link;
        n_exp  = r_exp;
        n_cmd  = CMD_NONE;
        n_ev   = EV_NONE;
        n_hr   = 8'h00;
        n_mn   = 8'h00;
        if (!reply_ok) begin
            n_link = LS_ERROR;
            n_exp  = REP_REBOOT;
            n_cmd  = CMD_R1;
        end else if (r_link <= LS_INIT) begin
            // setup sequence
            n_link = r_link + 4'd1;
            case (r_link)
                4'd0: n_exp = REP_CMD;
                4'd1: begin
                    n_exp = REP_AOK;
                    n_cmd = CMD_SF;
                end
                4'd2: n_cmd = CMD_SN;
                4'd3: n_cmd = CMD_SDR;
                4'd4: n_cmd = CMD_SS;
                4'd5: n_cmd = CMD_SR;
                4'd6: begin
                    n_exp = REP_REBOOT;
                    n_cmd = CMD_R1;
                end
                4'd7: n_exp = REP_CMD;
                default: n_exp = REP_NONE;
            endcase
        end else begin
            // classify once set up
            n_exp = REP_NONE;
            if (match[PAT_R]) begin
                if (r_len == LEN_TIME) begin
                    n_hr = {r_hr_hi, 4'h0} + r_hr_lo;
                    n_mn = {r_mn_hi, 4'h0} + r_mn_lo;
                    n_ev = EV_SET_TIME;
                end else if (r_len == LEN_LOCATE) begin
                    n_ev = EV_LOCATING;
                end
            end else if (match[PAT_NOTIFY]) begin
                if (r_len == LEN_NOTIFY) begin
                    n_ev = EV_ALERT_SMS;
                end
            end else if (match[PAT_ERR]) begin
                n_link = LS_ERROR;
                n_exp  = REP_REBOOT;
                n_cmd  = CMD_R1;
            end else if (match[PAT_CMD]) begin
                n_link = r_link;
            end else if (match[PAT_AOK]) begin
                if (r_link == LS_CONNECTING) begin
                    n_link = LS_CONNECTED;
                    n_ev   = EV_CONNECTED;
                    n_cmd  = CMD_CURV;
                end
            end else if (match[PAT_CONEND]) begin
                n_link = LS_INIT;
            end else if (match[PAT_CONN]) begin
                n_link = LS_CONNECTING;
                n_exp  = REP_AOK;
                n_cmd  = CMD_CUWC;
            end
        end
    end

    // sequencer, line state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_link      <= LS_START;
            r_exp       <= REP_CMD;
            r_out_valid <= 1'b0;
            r_cmp_on    <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd <= CMD_NONE;
                        r_ev  <= EV_NONE;
                        r_hr  <= 8'h00;
                        r_mn  <= 8'h00;
                        case (t_op'(i_op))
                            OP_INIT: begin
                                r_len       <= '0;
                                r_link      <= LS_START;
                                r_exp       <= REP_CMD;
                                r_out_valid <= 1'b1;
                            end
                            OP_BYTE: begin
                                if (i_rx_byte == CHAR_NL) begin
                                    r_state  <= S_SCAN;
                                    r_idx    <= '0;
                                    r_cmp_on <= 1'b0;
                                    r_flag   <= '1;
                                end else begin
                                    if (r_len == ADDR_W'(LINE_DEPTH - 1)) begin
                                        r_len <= '0;
                                    end else begin
                                        r_len <= r_len + 1'b1;
                                    end
                                    r_out_valid <= 1'b1;
                                end
                            end
                            default: r_out_valid <= 1'b1;
                        endcase
                    end
                end
                S_SCAN: begin
                    r_cmp_on  <= 1'b1;
                    r_cmp_idx <= r_idx;
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_cmp_on <= 1'b0;
                    r_state  <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_link      <= n_link;
                    r_exp       <= n_exp;
                    r_cmd       <= n_cmd;
                    r_ev        <= n_ev;
                    r_hr        <= n_hr;
                    r_mn        <= n_mn;
                    r_len       <= '0;
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            // fold in the character from the registered read, addressed by r_cmp_idx
            if (r_cmp_on) begin
                r_flag <= n_flag;
                if (r_cmp_idx == POS_HR_HI) begin
                    r_hr_hi <= dig[3:0];
                end
                if (r_cmp_idx == POS_HR_LO) begin
                    r_hr_lo <= dig;
                end
                if (r_cmp_idx == POS_MN_HI) begin
                    r_mn_hi <= dig[3:0];
                end
                if (r_cmp_idx == POS_MN_LO) begin
                    r_mn_lo <= dig;
                end
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_command_id     = r_cmd;
    assign o_event_code     = r_ev;
    assign o_hour_value     = r_hr;
    assign o_minute_value   = r_mn;
    assign o_link_state_out = r_link;

endmodule

>>> design/bles_line_ram.sv
// line store: one write port, one registered read port
module bles_line_ram
    import bles_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [LINE_DEPTH];
    logic [7:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/bles_checker.sv
// port checker for the reply line sequencer, bound to the top level
module bles_checker
    import bles_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_op,
    input logic [7:0] i_rx_byte,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [3:0] o_command_id,
    input logic [2:0] o_event_code,
    input logic [7:0] o_hour_value,
    input logic [7:0] o_minute_value,
    input logic [3:0] o_link_state_out
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_command_id)
        && $stable(o_event_code) && $stable(o_hour_value) && $stable(o_minute_value)
        && $stable(o_link_state_out))
        else $error("result changed while stalled");

    // one item at a time: never ready while a result waits
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready with result pending");

    // initialize restarts the link with no command
    a_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_op == OP_INIT) |=> o_out_valid
        && (o_link_state_out == LS_START) && (o_command_id == CMD_NONE)
        && (o_event_code == EV_NONE))
        else $error("initialize result wrong");

    // time fields are zero unless a set time event
    a_time_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_code != EV_SET_TIME) |->
        (o_hour_value == 8'h00) && (o_minute_value == 8'h00))
        else $error("time fields set without set time");

endmodule

bind ble_module_reply_line_sequencer bles_checker u_bles_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .i_op             (i_op),
    .i_rx_byte        (i_rx_byte),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_command_id     (o_command_id),
    .o_event_code     (o_event_code),
    .o_hour_value     (o_hour_value),
    .o_minute_value   (o_minute_value),
    .o_link_state_out (o_link_state_out)
);
